FILE: design/cdw_pkg.sv
package cdw_pkg;

  localparam int unsigned MaxDigits = 10;
  localparam int unsigned DigitLimit = (MaxDigits < 10) ? MaxDigits : 10;
  localparam int unsigned DigitIdxW = (DigitLimit > 1) ? $clog2(DigitLimit) : 1;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAddrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [7:0] WrapColumnRst = 8'd16;
  localparam logic [7:0] LineTwoRst = 8'hc0;
  localparam logic [7:0] AsciiZero = 8'd48;
  localparam logic [31:0] RecipTen = 32'hcccccccd;
  localparam int unsigned RecipShift = 35;

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_CMD  = 2'd1,
    OP_NUM  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic {
    REG_WRAP_COLUMN = 1'b0,
    REG_LINE_TWO    = 1'b1
  } reg_e;

  typedef struct packed {
    op_e         kind;
    logic [31:0] value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

FILE: design/cdw_front.sv
module cdw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          op_i,
  input  logic [31:0]         value_i,
  output cdw_pkg::queue_head_t head_o,
  input  logic                head_pop_i
);
  import cdw_pkg::*;

  item_t                 entries_q [QueueDepth];
  logic [QueueAddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueueAddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  count_q, count_d;
  op_e                   kind;
  logic                  enq;
  logic                  deq;

  // classify the incoming op, unused codes are dropped
  always_comb begin
    case (op_i)
      OP_CHAR: kind = OP_CHAR;
      OP_CMD:  kind = OP_CMD;
      OP_NUM:  kind = OP_NUM;
      default: kind = OP_NONE;
    endcase
  end

  assign full = (count_q == QueueCntW'(QueueDepth));
  assign enq  = push && !full && (kind != OP_NONE);
  assign deq  = head_pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == QueueAddrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (deq) begin
      rd_ptr_d = (rd_ptr_q == QueueAddrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({enq, deq})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      entries_q[wr_ptr_q] <= '{kind: kind, value: value_i};
    end
  end

endmodule

FILE: design/cdw_back.sv
module cdw_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cdw_pkg::queue_head_t head_i,
  output logic                 head_pop_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output logic                 empty,
  input  logic                 pop,
  output logic                 reg_select_o,
  output logic [7:0]           bus_byte_o,
  output logic                 last_o
);
  import cdw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_DATA = 5'b00100,
    S_WRAP = 5'b01000,
    S_CMD  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [7:0]           wrap_col_q, line_two_q, col_q, col_d;
  logic [31:0]          value_q, value_d;
  logic                 char_mode_q, char_mode_d;
  logic [3:0]           digits_q [DigitLimit];
  logic [DigitIdxW-1:0] cnt_q, cnt_d, top_q, top_d, idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_rs_q, out_rs_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 out_last_q, out_last_d;
  logic                 slot_free;
  logic [63:0]          prod;
  logic [31:0]          quo;
  logic [31:0]          rem_full;
  logic [3:0]           rem;
  logic [7:0]           col_inc;
  logic                 wrap_hit;
  logic                 digit_we;

  assign cfg_ready_o  = 1'b1;
  assign empty        = !out_valid_q;
  assign reg_select_o = out_rs_q;
  assign bus_byte_o   = out_byte_q;
  assign last_o       = out_last_q;
  assign slot_free    = !out_valid_q || pop;

  // divide by ten through the reciprocal
  assign prod     = value_q * RecipTen;
  assign quo      = 32'(prod >> RecipShift);
  assign rem_full = value_q - (quo << 3) - (quo << 1);
  assign rem      = rem_full[3:0];

  assign col_inc  = col_q + 8'd1;
  assign wrap_hit = (col_inc == wrap_col_q);

  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    char_mode_d = char_mode_q;
    cnt_d       = cnt_q;
    top_d       = top_q;
    idx_d       = idx_q;
    col_d       = col_q;
    head_pop_o  = 1'b0;
    digit_we    = 1'b0;
    out_valid_d = out_valid_q && !pop;
    out_rs_d    = out_rs_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          head_pop_o = 1'b1;
          value_d    = head_i.item.value;
          cnt_d      = '0;
          top_d      = '0;
          idx_d      = '0;
          case (head_i.item.kind)
            OP_CHAR: begin
              char_mode_d = 1'b1;
              state_d     = S_DATA;
            end
            OP_CMD: state_d = S_CMD;
            OP_NUM: begin
              char_mode_d = 1'b0;
              state_d     = S_DIV;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        digit_we = 1'b1;
        value_d  = quo;
        cnt_d    = cnt_q + 1'b1;
        if (rem != 4'd0) begin
          top_d = cnt_q;
        end
        if (quo == '0 || cnt_q == DigitIdxW'(DigitLimit - 1)) begin
          idx_d   = (rem != 4'd0) ? cnt_q : top_q;
          state_d = S_DATA;
        end
      end
      S_DATA: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_rs_d    = 1'b1;
          out_byte_d  = char_mode_q ? value_q[7:0] : AsciiZero + {4'd0, digits_q[idx_q]};
          out_last_d  = (idx_q == '0) && !wrap_hit;
          col_d       = col_inc;
          if (wrap_hit) begin
            state_d = S_WRAP;
          end else if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      S_WRAP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_rs_d    = 1'b0;
          out_byte_d  = line_two_q;
          out_last_d  = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_DATA;
          end
        end
      end
      S_CMD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_rs_d    = 1'b0;
          out_byte_d  = value_q[7:0];
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      out_valid_q <= 1'b0;
      wrap_col_q  <= WrapColumnRst;
      line_two_q  <= LineTwoRst;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_WRAP_COLUMN: wrap_col_q <= cfg_data_i;
          REG_LINE_TWO:    line_two_q <= cfg_data_i;
          default:         wrap_col_q <= wrap_col_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    char_mode_q <= char_mode_d;
    cnt_q       <= cnt_d;
    top_q       <= top_d;
    idx_q       <= idx_d;
    out_rs_q    <= out_rs_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    if (digit_we) begin
      digits_q[cnt_q] <= rem;
    end
  end

endmodule

FILE: design/char_display_writer_with_decimal.sv
// path: a push is registered in the queue and taken by the idle state, then the
// data or command state writes it out; a number is first split into decimal digits
// (up to 10) by the divide state, one digit per cycle. Items are handled one at a
// time while the queue holds more; writes wait on pop; a wrap adds the line-two command.
// reset: rst_ni async active low empties the queue, returns the state to idle, clears
// the column count to 0 and sets wrap column to 16 and line-two command to 0xc0
module char_display_writer_with_decimal (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [31:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic        reg_select_o,
  output logic [7:0]  bus_byte_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import cdw_pkg::*;

  queue_head_t head;
  logic        head_pop;

  cdw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .op_i       (op_i),
    .value_i    (value_i),
    .head_o     (head),
    .head_pop_i (head_pop)
  );

  cdw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .empty        (empty),
    .pop          (pop),
    .reg_select_o (reg_select_o),
    .bus_byte_o   (bus_byte_o),
    .last_o       (last_o)
  );

endmodule

FILE: test/cdw_write_checker.sv
`timescale 1ns / 1ps
module cdw_write_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  op_i,
  input  logic [31:0] value_i,
  input  logic        empty,
  input  logic        pop,
  input  logic        reg_select_i,
  input  logic [7:0]  bus_byte_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o,
  output int unsigned item_count_o,
  output int unsigned write_count_o,
  output int unsigned line_two_count_o
);
  import cdw_pkg::*;

  localparam int unsigned ReportLimit = 10;
  localparam int unsigned DigitCap = (MaxDigits < 10) ? MaxDigits : 10;

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       last;
  } bus_write_t;

  bus_write_t  expected_writes[$];
  logic [7:0]  column_count = '0;
  logic [7:0]  wrap_column = WrapColumnRst;
  logic [7:0]  line_two_cmd = LineTwoRst;
  int unsigned mismatches = 0;
  int unsigned items_seen = 0;
  int unsigned writes_seen = 0;
  int unsigned line_two_seen = 0;

  task automatic emit_data(input logic [7:0] ch);
    expected_writes.push_back(bus_write_t'{1'b1, ch, 1'b0});
    column_count = column_count + 8'd1;
    if (column_count == wrap_column) begin
      expected_writes.push_back(bus_write_t'{1'b0, line_two_cmd, 1'b0});
      line_two_seen++;
    end
  endtask

  task automatic predict_writes(input op_e kind, input logic [31:0] value);
    logic [3:0]  digits [10];
    logic [31:0] rest;
    bus_write_t  tail;
    int unsigned first_size;
    int          n;
    first_size = expected_writes.size();
    rest = value;
    case (kind)
      OP_CHAR: emit_data(value[7:0]);
      OP_CMD: expected_writes.push_back(bus_write_t'{1'b0, value[7:0], 1'b0});
      OP_NUM: begin
        // least significant digit first, then drop leading zeros
        for (int i = 0; i < DigitCap; i++) begin
          digits[i] = 4'(rest % 32'd10);
          rest = rest / 32'd10;
        end
        n = int'(DigitCap);
        while (n > 1 && digits[n-1] == 4'd0) n--;
        for (int i = n - 1; i >= 0; i--) emit_data(AsciiZero + {4'd0, digits[i]});
      end
      default: ;
    endcase
    if (expected_writes.size() > first_size) begin
      tail = expected_writes.pop_back();
      tail.last = 1'b1;
      expected_writes.push_back(tail);
    end
  endtask

  always @(posedge clk_i) begin : watch
    bus_write_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (reg_e'(cfg_index_i) == REG_WRAP_COLUMN) begin
          wrap_column = cfg_data_i;
        end else begin
          line_two_cmd = cfg_data_i;
        end
      end
      if (pop && !empty) begin
        writes_seen++;
        if (expected_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("unexpected write: rs=%0b byte=%02h last=%0b",
                     reg_select_i, bus_byte_i, last_i);
          end
        end else begin
          want = expected_writes.pop_front();
          if (want.rs !== reg_select_i || want.data !== bus_byte_i ||
              want.last !== last_i) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("write %0d: expected rs=%0b byte=%02h last=%0b,",
                       writes_seen, want.rs, want.data, want.last);
              $display("  got rs=%0b byte=%02h last=%0b",
                       reg_select_i, bus_byte_i, last_i);
            end
          end
        end
      end
      if (push && !full) begin
        items_seen++;
        predict_writes(op_e'(op_i), value_i);
      end
    end
    fail_count_o     <= mismatches;
    outstanding_o    <= expected_writes.size();
    item_count_o     <= items_seen;
    write_count_o    <= writes_seen;
    line_two_count_o <= line_two_seen;
  end

endmodule

FILE: test/char_display_writer_with_decimal_tb.sv
`timescale 1ns / 1ps
module char_display_writer_with_decimal_tb;
  import cdw_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseItems = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [1:0]  op_i;
  logic [31:0] value_i;
  logic        empty;
  logic        pop;
  logic        reg_select_o;
  logic [7:0]  bus_byte_o;
  logic        last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;

  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned item_count;
  int unsigned write_count;
  int unsigned line_two_count;

  char_display_writer_with_decimal uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .value_i      (value_i),
    .empty        (empty),
    .pop          (pop),
    .reg_select_o (reg_select_o),
    .bus_byte_o   (bus_byte_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  cdw_write_checker write_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .op_i             (op_i),
    .value_i          (value_i),
    .empty            (empty),
    .pop              (pop),
    .reg_select_i     (reg_select_o),
    .bus_byte_i       (bus_byte_o),
    .last_i           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding),
    .item_count_o     (item_count),
    .write_count_o    (write_count),
    .line_two_count_o (line_two_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("char_display_writer_with_decimal regression: fail");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off to back the block up
  initial begin : result_sink
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        pop <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_item(input op_e kind, input logic [31:0] value);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    push    <= 1'b1;
    op_i    <= kind;
    value_i <= value;
    do @(posedge clk_i); while (full);
  endtask

  task automatic write_reg(input reg_e index, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_number();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 9);
      2: return $urandom_range(0, 99999);
      3: begin
        // powers of ten and the all-nines just below them
        repeat ($urandom_range(1, 9)) p = p * 10;
        return p - $urandom_range(0, 1);
      end
      4: return 32'hffff_ffff - $urandom_range(0, 500);
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) send_item(OP_CHAR, $urandom());
    else if (pick < 53) send_item(OP_CMD, $urandom());
    else if (pick < 95) send_item(OP_NUM, random_number());
    else send_item(OP_NONE, $urandom());
  endtask

  task automatic run_phase(input logic [7:0] wrap_col, input logic [7:0] cmd,
                           input bit hold, input bit quiet);
    wait_drained();
    write_reg(REG_WRAP_COLUMN, wrap_col);
    write_reg(REG_LINE_TWO, cmd);
    cfg_valid_i <= 1'b0;
    if (hold) hold_req <= 1'b1;
    if (quiet) idle_on <= 1'b0;
    repeat (PhaseItems) send_random_item();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    op_i        <= OP_CHAR;
    value_i     <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_WRAP_COLUMN;
    cfg_data_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes, wide characters and commands, the unused op, digit edges
    send_item(OP_CHAR, 32'h0000_0000);
    send_item(OP_CHAR, 32'hffff_ff7e);
    send_item(OP_CHAR, 32'h5a5a_a5ff);
    send_item(OP_CMD, 32'h0000_0000);
    send_item(OP_CMD, 32'ha5a5_5aff);
    send_item(OP_NONE, 32'hffff_ffff);
    send_item(OP_NUM, 32'd0);
    send_item(OP_NUM, 32'd9);
    send_item(OP_NUM, 32'd10);
    send_item(OP_NUM, 32'd99);
    send_item(OP_NUM, 32'd100);
    send_item(OP_NUM, 32'd999_999_999);
    send_item(OP_NUM, 32'd1_000_000_000);
    send_item(OP_NUM, 32'd4_294_967_295);
    send_item(OP_NUM, 32'd4_000_000_000);
    send_item(OP_NONE, 32'h0000_0000);
    send_item(OP_NUM, 32'd1_234_567_890);
    send_item(OP_NUM, 32'd2_147_483_648);
    send_item(OP_CMD, 32'h0000_0055);
    send_item(OP_CHAR, 32'h0000_0041);

    run_phase(8'd1, 8'h00, 1'b0, 1'b0);
    run_phase(8'd255, 8'hff, 1'b1, 1'b0);
    run_phase(8'd0, 8'h80, 1'b0, 1'b0);
    run_phase(8'd7, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
    run_phase(8'd16, 8'hc0, 1'b0, 1'b1);
    wait_drained();

    $display("covered %0d items and %0d display writes, %0d of them line-two commands,",
             item_count, write_count, line_two_count);
    $display("under reset register values and five written settings, one long result stall");
    if (fail_count == 0 && outstanding == 0) begin
      $display("char_display_writer_with_decimal regression: pass");
    end else begin
      $display("char_display_writer_with_decimal regression: fail");
    end
    $finish;
  end

endmodule
